@@ hdl/chtbl_pkg.sv @@
package chtbl_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int REF_WIDTH   = 16;

   localparam int CAPACITY = (TABLE_DEPTH < 256) ? TABLE_DEPTH : 256;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   localparam int GRP_W = 16;
   localparam int GRP_N = (CAPACITY + GRP_W - 1) / GRP_W;
   localparam int POS_W = $clog2(GRP_W);

   localparam int MODE_W     = 2;
   localparam int SLOT_W     = 8;
   localparam int CHECK_W    = 32;
   localparam int STATUS_W   = 2;
   localparam int REFS_OUT_W = 16;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 64;
   localparam int RSP_USED_W  = SLOT_W + CHECK_W + REFS_OUT_W + 1;

   typedef enum logic [MODE_W-1:0] {
      OP_CREATE  = 2'd0,
      OP_DESTROY = 2'd1,
      OP_GET     = 2'd2,
      OP_PUT     = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK         = 2'd0,
      STS_BAD_HANDLE = 2'd1,
      STS_TABLE_FULL = 2'd2,
      STS_REFS_SAT   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      SLOT_EMPTY   = 2'd0,
      SLOT_PENDING = 2'd1,
      SLOT_ACTIVE  = 2'd2
   } slot_st_type;

   typedef enum logic {
      CTL_IDLE,
      CTL_EXEC
   } ctl_state_type;

   typedef struct packed {
      slot_st_type          state;
      logic [REF_WIDTH-1:0] refs;
      logic [CHECK_W-1:0]   check;
   } entry_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
   } rd_req_type;

   typedef struct packed {
      logic             we;
      logic             occ_clr;
      logic [IDX_W-1:0] addr;
      entry_type        data;
   } wr_req_type;

   typedef struct packed {
      logic             any;
      logic [IDX_W-1:0] idx;
   } free_type;

endpackage

@@ hdl/chtbl_store.sv @@
module chtbl_store
   import chtbl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  rd_req_type rd_req,
   input  wr_req_type wr_req,
   output entry_type  rd_entry,
   output free_type   free
);

   entry_type slot_mem [CAPACITY];

   entry_type                  rd_data_ff;
   logic                       rd_valid_ff;
   logic                       rd_valid_in;
   logic [CAPACITY-1:0]        occ_ff;
   logic [CAPACITY-1:0]        occ_in;
   logic [GRP_N*GRP_W-1:0]     occ_pad;
   logic [GRP_N-1:0]           grp_any_ff;
   logic [GRP_N-1:0]           grp_any_in;
   logic [GRP_N-1:0][POS_W-1:0] grp_pos_ff;
   logic [GRP_N-1:0][POS_W-1:0] grp_pos_in;

   always_ff @(posedge clock) begin
      if (wr_req.we && !wr_req.occ_clr) begin
         slot_mem[wr_req.addr] <= wr_req.data;
      end
      if (rd_req.en) begin
         rd_data_ff <= slot_mem[rd_req.addr];
      end
   end

   always_comb begin
      occ_in = occ_ff;
      if (wr_req.we) begin
         occ_in[wr_req.addr] = !wr_req.occ_clr;
      end
      rd_valid_in = rd_valid_ff;
      if (rd_req.en) begin
         rd_valid_in = occ_ff[rd_req.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff      <= '0;
         rd_valid_ff <= 1'b0;
         grp_any_ff  <= '0;
      end else begin
         occ_ff      <= occ_in;
         rd_valid_ff <= rd_valid_in;
         grp_any_ff  <= grp_any_in;
      end
   end

   always_ff @(posedge clock) begin
      grp_pos_ff <= grp_pos_in;
   end

   // pad slots past capacity as occupied
   always_comb begin
      occ_pad                 = '1;
      occ_pad[CAPACITY-1:0]   = occ_ff;
   end

   always_comb begin
      for (int g = 0; g < GRP_N; g++) begin
         grp_any_in[g] = ~&occ_pad[g*GRP_W +: GRP_W];
         grp_pos_in[g] = '0;
         for (int p = GRP_W - 1; p >= 0; p--) begin
            if (!occ_pad[g*GRP_W + p]) begin
               grp_pos_in[g] = POS_W'(p);
            end
         end
      end
   end

   always_comb begin
      free.any = 1'b0;
      free.idx = '0;
      for (int g = GRP_N - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) begin
            free.any = 1'b1;
            free.idx = IDX_W'(g * GRP_W + int'(grp_pos_ff[g]));
         end
      end
   end

   assign rd_entry = rd_valid_ff ? rd_data_ff : entry_type'('0);

endmodule

@@ hdl/chtbl_ctrl.sv @@
module chtbl_ctrl
   import chtbl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [MODE_W-1:0]      req_tuser,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [STATUS_W-1:0]    rsp_tuser,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output rd_req_type             rd_req,
   output wr_req_type             wr_req,
   input  entry_type              rd_entry,
   input  free_type               free
);

   ctl_state_type state_ff, state_in;

   op_type               item_op_ff;
   logic [SLOT_W-1:0]    item_slot_ff;
   logic [CHECK_W-1:0]   item_chk_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]    rsp_idx_ff, rsp_idx_in;
   logic [CHECK_W-1:0]   rsp_chk_ff, rsp_chk_in;
   logic [REF_WIDTH-1:0] rsp_refs_ff, rsp_refs_in;
   logic                 rsp_rel_ff, rsp_rel_in;

   logic                 accept;
   logic                 in_range;
   logic                 chk_eq;
   logic                 active_ok;
   logic                 held_ok;
   logic                 drop_en;
   slot_st_type          drop_state;
   logic [IDX_W-1:0]     item_addr;
   wr_req_type           wr_c;

   assign accept = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CTL_IDLE: begin
            if (accept) begin
               state_in = CTL_EXEC;
            end
         end
         CTL_EXEC: begin
            state_in = CTL_IDLE;
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready  = (state_ff == CTL_IDLE) && (!rsp_valid_ff || rsp_tready);
      rd_req.en   = accept;
      rd_req.addr = req_tdata[IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CTL_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_op_ff   <= op_type'(req_tuser);
         item_slot_ff <= req_tdata[SLOT_W-1:0];
         item_chk_ff  <= req_tdata[SLOT_W +: CHECK_W];
      end
      if (state_ff == CTL_EXEC) begin
         rsp_status_ff <= rsp_status_in;
         rsp_idx_ff    <= rsp_idx_in;
         rsp_chk_ff    <= rsp_chk_in;
         rsp_refs_ff   <= rsp_refs_in;
         rsp_rel_ff    <= rsp_rel_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (state_ff == CTL_EXEC) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign item_addr = item_slot_ff[IDX_W-1:0];
   assign in_range  = {1'b0, item_slot_ff} < (SLOT_W + 1)'(CAPACITY);
   assign chk_eq    = rd_entry.check == item_chk_ff;
   assign active_ok = in_range && (rd_entry.state == SLOT_ACTIVE) && chk_eq;
   assign held_ok   = in_range && chk_eq &&
                      ((rd_entry.state == SLOT_ACTIVE) || (rd_entry.state == SLOT_PENDING));

   always_comb begin
      rsp_status_in = STS_BAD_HANDLE;
      rsp_idx_in    = item_slot_ff;
      rsp_chk_in    = '0;
      rsp_refs_in   = '0;
      rsp_rel_in    = 1'b0;
      wr_c.we       = 1'b0;
      wr_c.occ_clr  = 1'b0;
      wr_c.addr     = item_addr;
      wr_c.data     = rd_entry;
      drop_en       = 1'b0;
      drop_state    = rd_entry.state;

      unique case (item_op_ff)
         OP_CREATE: begin
            rsp_idx_in = '0;
            if (item_chk_ff == '0) begin
               rsp_status_in = STS_BAD_HANDLE;
            end else if (!free.any) begin
               rsp_status_in = STS_TABLE_FULL;
            end else begin
               rsp_status_in    = STS_OK;
               rsp_idx_in       = SLOT_W'(free.idx);
               rsp_chk_in       = item_chk_ff;
               rsp_refs_in      = REF_WIDTH'(1);
               wr_c.we          = 1'b1;
               wr_c.addr        = free.idx;
               wr_c.data.state  = SLOT_ACTIVE;
               wr_c.data.refs   = REF_WIDTH'(1);
               wr_c.data.check  = item_chk_ff;
            end
         end
         OP_DESTROY: begin
            drop_en    = active_ok;
            drop_state = SLOT_PENDING;
         end
         OP_GET: begin
            if (active_ok) begin
               rsp_chk_in = rd_entry.check;
               if (&rd_entry.refs) begin
                  rsp_status_in = STS_REFS_SAT;
                  rsp_refs_in   = rd_entry.refs;
               end else begin
                  rsp_status_in  = STS_OK;
                  rsp_refs_in    = rd_entry.refs + REF_WIDTH'(1);
                  wr_c.we        = 1'b1;
                  wr_c.data.refs = rd_entry.refs + REF_WIDTH'(1);
               end
            end
         end
         OP_PUT: begin
            drop_en = held_ok;
         end
         default: begin
            rsp_status_in = STS_BAD_HANDLE;
         end
      endcase

      // drop one reference; free the entry when the last one goes
      if (drop_en) begin
         wr_c.we         = 1'b1;
         wr_c.data.state = drop_state;
         if (rd_entry.refs == '0) begin
            rsp_status_in = STS_BAD_HANDLE;
         end else if (rd_entry.refs == REF_WIDTH'(1)) begin
            rsp_status_in = STS_OK;
            rsp_chk_in    = rd_entry.check;
            rsp_rel_in    = 1'b1;
            wr_c.occ_clr  = 1'b1;
         end else begin
            rsp_status_in  = STS_OK;
            rsp_chk_in     = rd_entry.check;
            rsp_refs_in    = rd_entry.refs - REF_WIDTH'(1);
            wr_c.data.refs = rd_entry.refs - REF_WIDTH'(1);
         end
      end

      wr_req = wr_c;
      if (state_ff != CTL_EXEC) begin
         wr_req.we = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - RSP_USED_W)'(0), rsp_rel_ff,
                        REFS_OUT_W'(rsp_refs_ff), rsp_chk_ff, rsp_idx_ff};

endmodule

@@ hdl/checked_handle_table_core.sv @@
// An accepted item's entry is read from the table into a register, then
// modified and written back while its result is registered; a new item is
// taken only after that write back, and not while a result is stalled.
// Reset: synchronous, active high; clears every entry to empty at once
// through per-slot occupancy bits, so items are accepted right after reset.
module checked_handle_table_core
   import chtbl_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [MODE_W-1:0]      req_tuser,  // mode
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // slot_index, check_word
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [STATUS_W-1:0]    rsp_tuser,  // status
   output logic [RSP_TDATA_W-1:0] rsp_tdata   // result_index, result_check,
                                              // refs_after, released, zero pad
);

   rd_req_type rd_req;
   wr_req_type wr_req;
   entry_type  rd_entry;
   free_type   free;

   chtbl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rd_req     (rd_req),
      .wr_req     (wr_req),
      .rd_entry   (rd_entry),
      .free       (free)
   );

   chtbl_store u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_req   (rd_req),
      .wr_req   (wr_req),
      .rd_entry (rd_entry),
      .free     (free)
   );

endmodule

@@ hdl/chtbl_checker.sv @@
module chtbl_checker
   import chtbl_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [MODE_W-1:0]      req_tuser,
   input logic [REQ_TDATA_W-1:0] req_tdata,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [STATUS_W-1:0]    rsp_tuser,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled item changed");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted while one is in flight");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> ##2 rsp_tvalid)
      else $error("result missing two cycles after accept");

   a_release_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[56] |->
         (rsp_tuser == STS_OK) && (rsp_tdata[55:40] == '0))
      else $error("release with bad status or nonzero count");

endmodule

bind checked_handle_table_core chtbl_checker u_checker (.*);
